### rtl/core/dare_pkg.sv
// Shared types and constants for the dual attack-release envelope.
// No dependencies.
`default_nettype none

package dare_pkg;

    // Configuration register widths and indexes
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_B = 2'd3;

    localparam logic [CFG_W-1:0] DURATION_RESET = 24'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    // Decisions for one channel on one tick
    typedef struct packed {
        logic active;      // channel does anything this tick
        logic phase_next;  // 1 = attack
        logic div_go;      // level comes from a division
        logic env_clr;     // level goes to zero (trigger or release over)
    } tick_ctl_t;

endpackage

`default_nettype wire

### rtl/core/dare_in_if.sv
// Input channel: one tick beat carrying a trigger bit per channel.
// No dependencies.
`default_nettype none

interface dare_in_if;
    logic valid;
    logic ready;
    logic trigger_a;
    logic trigger_b;

    modport source (output valid, output trigger_a, output trigger_b, input ready);
    modport sink   (input valid, input trigger_a, input trigger_b, output ready);
endinterface

`default_nettype wire

### rtl/core/dare_out_if.sv
// Output channel: one beat of levels and attack flags per tick.
// No dependencies.
`default_nettype none

interface dare_out_if #(
    parameter int LEVEL_W = 17
);
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic               attacking_a;
    logic               attacking_b;

    modport source (output valid, output level_a, output level_b,
                    output attacking_a, output attacking_b, input ready);
    modport sink   (input valid, input level_a, input level_b,
                    input attacking_a, input attacking_b, output ready);
endinterface

`default_nettype wire

### rtl/core/dare_div.sv
// Radix-2 restoring divider for fractions num/den with num <= den.
// Produces one integer bit and Q_W-1 fraction bits, one bit per cycle.
`default_nettype none

module dare_div #(
    parameter int NUM_W = 24,
    parameter int Q_W   = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  done,
    output logic [Q_W-1:0]        quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [NUM_W:0]   diff;

    always_comb
    begin
        ge       = rem_reg >= {1'b0, den_reg};
        diff     = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        // diff < den here, so the shift cannot overflow
        rem_next = {diff[NUM_W-1:0], 1'b0};
        quo_next = {quo_reg[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/core/dare_tick_eval.sv
// Phase and tick-count decisions for one channel on one tick.
// Uses dare_pkg; drives the divider operands.
`default_nettype none

module dare_tick_eval #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                    trig,
    input  wire logic [TIME_BITS-1:0]    ticks,
    input  wire logic                    phase,
    input  wire logic                    env_nz,
    input  wire logic [dare_pkg::CFG_W-1:0] atk,
    input  wire logic [dare_pkg::CFG_W-1:0] rel,
    output dare_pkg::tick_ctl_t          ctl,
    output logic [TIME_BITS-1:0]         ticks_next,
    output logic [dare_pkg::CFG_W-1:0]   num,
    output logic [dare_pkg::CFG_W-1:0]   den
);

    localparam int CW = (TIME_BITS > dare_pkg::CFG_W) ? TIME_BITS : dare_pkg::CFG_W;

    logic [TIME_BITS-1:0] t0, t1;
    logic [CW-1:0]        t0w, t1w, aw, rw;
    logic                 ph0, ph1, att_lt, enter_rel, rel_lt, rel_gt;

    always_comb
    begin
        t0        = trig ? '0 : ticks;
        ph0       = trig | phase;
        t0w       = CW'(t0);
        aw        = CW'(atk);
        rw        = CW'(rel);
        att_lt    = ph0 && (t0w < aw);
        enter_rel = ph0 && (t0w > aw);
        ph1       = ph0 & ~enter_rel;
        t1        = enter_rel ? '0 : t0;
        t1w       = CW'(t1);
        rel_lt    = !ph1 && (t1w < rw);
        rel_gt    = !ph1 && (t1w > rw);

        // saturating tick count
        ticks_next = (t1 == '1) ? t1 : (t1 + TIME_BITS'(1));

        // t1 below the duration, so it fits the register width
        num = att_lt ? dare_pkg::CFG_W'(t1w) : (rel - dare_pkg::CFG_W'(t1w));
        den = att_lt ? atk : rel;

        ctl.active     = trig | env_nz | phase;
        ctl.phase_next = ph1;
        ctl.div_go     = att_lt | rel_lt;
        ctl.env_clr    = trig | rel_gt;
    end

endmodule

`default_nettype wire

### rtl/core/dual_attack_release_envelope.sv
// Dual linear attack-release envelope, one tick per input beat.
// Each beat goes through channel A, then channel B, in the evaluate state, with a divide
// state for each channel that divides; each division yields FRAC_BITS+1 quotient bits on
// one shared divider. The next beat is taken as soon as the sequencer is idle, even
// while the previous result still waits in the output register.
// Reset (rst_n, async low): durations to 1000, both channels idle at level zero.
`default_nettype none

module dual_attack_release_envelope #(
    parameter int TIME_BITS = 24,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dare_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dare_pkg::CFG_W-1:0]     cfg_data,
    dare_in_if.sink                             in_ch,
    dare_out_if.source                          out_ch
);

    localparam int LEVEL_W = FRAC_BITS + 1;
    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << FRAC_BITS;

    // ---------------------------------------------------------------
    // Configuration: attack/release lengths per channel (0 = A, 1 = B)
    // ---------------------------------------------------------------
    logic [dare_pkg::CFG_W-1:0] atk_reg [2];
    logic [dare_pkg::CFG_W-1:0] rel_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                atk_reg[i] <= dare_pkg::DURATION_RESET;
                rel_reg[i] <= dare_pkg::DURATION_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dare_pkg::REG_ATTACK_A:  atk_reg[0] <= cfg_data;
                dare_pkg::REG_RELEASE_A: rel_reg[0] <= cfg_data;
                dare_pkg::REG_ATTACK_B:  atk_reg[1] <= cfg_data;
                dare_pkg::REG_RELEASE_B: rel_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Channel state
    // ---------------------------------------------------------------
    logic [TIME_BITS-1:0] ticks_reg [2];
    logic                 phase_reg [2];
    logic [LEVEL_W-1:0]   env_reg   [2];
    logic                 trig_reg  [2];

    dare_pkg::seq_state_t state_reg, state_next;
    logic                 chan_reg;   // channel being worked on

    // Output register, decouples the sequencer from the sink
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] level_a_reg, level_b_reg;
    logic               attacking_a_reg, attacking_b_reg;

    // ---------------------------------------------------------------
    // Per-tick decisions for the selected channel
    // ---------------------------------------------------------------
    dare_pkg::tick_ctl_t        ctl;
    logic [TIME_BITS-1:0]       ticks_next;
    logic [dare_pkg::CFG_W-1:0] div_num, div_den;

    dare_tick_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .trig       (trig_reg[chan_reg]),
        .ticks      (ticks_reg[chan_reg]),
        .phase      (phase_reg[chan_reg]),
        .env_nz     (env_reg[chan_reg] != '0),
        .atk        (atk_reg[chan_reg]),
        .rel        (rel_reg[chan_reg]),
        .ctl        (ctl),
        .ticks_next (ticks_next),
        .num        (div_num),
        .den        (div_den)
    );

    // ---------------------------------------------------------------
    // Shared divider: level = num * 2^FRAC_BITS / den
    // ---------------------------------------------------------------
    logic               div_start;
    logic               div_done;
    logic [LEVEL_W-1:0] div_quo;

    dare_div #(
        .NUM_W (dare_pkg::CFG_W),
        .Q_W   (LEVEL_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic in_accept;
    logic load_out;
    logic chan_step;   // finished with the current channel

    always_comb
    begin
        in_accept = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        chan_step = 1'b0;
        case (state_reg)
            dare_pkg::ST_IDLE: in_accept = in_ch.valid;
            dare_pkg::ST_EVAL:
            begin
                div_start = ctl.active & ctl.div_go;
                chan_step = ~div_start;
            end
            dare_pkg::ST_DIV:  chan_step = div_done;
            dare_pkg::ST_DONE: load_out  = ~out_valid_reg | out_ch.ready;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dare_pkg::ST_IDLE:
                if (in_ch.valid)
                    state_next = dare_pkg::ST_EVAL;
            dare_pkg::ST_EVAL:
                if (div_start)
                    state_next = dare_pkg::ST_DIV;
                else if (chan_reg)
                    state_next = dare_pkg::ST_DONE;
            dare_pkg::ST_DIV:
                if (div_done)
                    state_next = chan_reg ? dare_pkg::ST_DONE : dare_pkg::ST_EVAL;
            dare_pkg::ST_DONE:
                if (load_out)
                    state_next = dare_pkg::ST_IDLE;
            default: state_next = dare_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dare_pkg::ST_IDLE;
            chan_reg  <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                ticks_reg[i] <= '0;
                phase_reg[i] <= 1'b0;
                env_reg[i]   <= '0;
                trig_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                trig_reg[0] <= in_ch.trigger_a;
                trig_reg[1] <= in_ch.trigger_b;
                chan_reg    <= 1'b0;
            end
            else if (chan_step)
                chan_reg <= 1'b1;

            // Idle channel: nothing changes
            if (state_reg == dare_pkg::ST_EVAL && ctl.active)
            begin
                ticks_reg[chan_reg] <= ticks_next;
                phase_reg[chan_reg] <= ctl.phase_next;
                if (ctl.env_clr)
                    env_reg[chan_reg] <= '0;
            end

            if (state_reg == dare_pkg::ST_DIV && div_done)
                env_reg[chan_reg] <= div_quo;
        end
    end

    // ---------------------------------------------------------------
    // Output beat
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            level_a_reg     <= env_reg[0];
            level_b_reg     <= env_reg[1];
            attacking_a_reg <= phase_reg[0];
            attacking_b_reg <= phase_reg[1];
        end
    end

    assign in_ch.ready        = (state_reg == dare_pkg::ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.level_a     = level_a_reg;
    assign out_ch.level_b     = level_b_reg;
    assign out_ch.attacking_a = attacking_a_reg;
    assign out_ch.attacking_b = attacking_b_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_starts_a: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg == dare_pkg::ST_EVAL && !chan_reg)
        else $error("accepted beat did not start on channel A");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == dare_pkg::ST_DIV)
        else $error("divider finished outside of the divide state");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg[0] <= FULL_SCALE && env_reg[1] <= FULL_SCALE)
        else $error("envelope level above full scale");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == dare_pkg::ST_IDLE)
        else $error("result load did not present a beat");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for dual_attack_release_envelope: drives tick beats,
// predicts the level beats of both channels and compares them field by field.
// Depends on dare_pkg, dare_in_if, dare_out_if and the block itself.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS = 24;
    localparam int FRAC_BITS = 16;
    localparam int LEVEL_W   = FRAC_BITS + 1;

    localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};

    // Worst case of one tick plus some margin, waited out after the last level beat.
    localparam int SETTLE_CYCLES  = 48;
    // Long receiver hold used to back the block up.
    localparam int HOLD_CYCLES    = 300;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic               attacking_a;
        logic               attacking_b;
    } level_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dare_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dare_pkg::CFG_W-1:0]     cfg_data;

    dare_in_if                      in_ch ();
    dare_out_if #(.LEVEL_W(LEVEL_W)) out_ch ();

    dual_attack_release_envelope #(
        .TIME_BITS(TIME_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // ------------------------------------------------------------------
    // Envelope predictor: durations, tick counters, phase and level of
    // channel A (index 0) and channel B (index 1).
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] dur_attack [2];
    logic [TIME_BITS-1:0] dur_release[2];
    logic [TIME_BITS-1:0] tick_count [2];
    logic                 in_attack  [2];
    logic [LEVEL_W-1:0]   level      [2];

    level_beat_t expected_levels_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int mismatch_count;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One tick of one channel. Idle channels (level zero, not attacking,
    // no trigger) keep everything as is.
    task automatic advance_channel(input int c, input logic trig);
        longint unsigned t;
        longint unsigned a;
        longint unsigned r;
        if (!(trig || level[c] != '0 || in_attack[c]))
            return;
        if (trig)
        begin
            tick_count[c] = '0;
            level[c]      = '0;
            in_attack[c]  = 1'b1;
        end
        t = 64'(tick_count[c]);
        a = 64'(dur_attack[c]);
        r = 64'(dur_release[c]);
        // Tests run in order, so the tick that leaves attack shows full scale.
        // Equality with a duration matches none of them: the level holds.
        if (in_attack[c] && t < a)
            level[c] = LEVEL_W'((t << FRAC_BITS) / a);
        if (in_attack[c] && t > a)
        begin
            in_attack[c] = 1'b0;
            t = '0;
        end
        if (!in_attack[c] && t < r)
            level[c] = LEVEL_W'(((r - t) << FRAC_BITS) / r);
        if (!in_attack[c] && t > r)
            level[c] = '0;
        // Counter saturates at all ones.
        tick_count[c] = (t < 64'(TICK_MAX)) ? TIME_BITS'(t + 64'd1) : TICK_MAX;
    endtask

    task automatic predict_tick(input logic trig_a, input logic trig_b);
        level_beat_t beat;
        advance_channel(0, trig_a);
        advance_channel(1, trig_b);
        beat.level_a     = level[0];
        beat.level_b     = level[1];
        beat.attacking_a = in_attack[0];
        beat.attacking_b = in_attack[1];
        expected_levels_q.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // Register writes: only called with nothing in flight.
    // ------------------------------------------------------------------
    task automatic write_durations(input logic [dare_pkg::CFG_W-1:0] att_a,
                                   input logic [dare_pkg::CFG_W-1:0] rel_a,
                                   input logic [dare_pkg::CFG_W-1:0] att_b,
                                   input logic [dare_pkg::CFG_W-1:0] rel_b);
        cfg_we    <= 1'b1;
        cfg_index <= dare_pkg::REG_ATTACK_A;
        cfg_data  <= att_a;
        @(posedge clk);
        cfg_index <= dare_pkg::REG_RELEASE_A;
        cfg_data  <= rel_a;
        @(posedge clk);
        cfg_index <= dare_pkg::REG_ATTACK_B;
        cfg_data  <= att_b;
        @(posedge clk);
        cfg_index <= dare_pkg::REG_RELEASE_B;
        cfg_data  <= rel_b;
        @(posedge clk);
        cfg_we <= 1'b0;
        dur_attack[0]  = att_a;
        dur_release[0] = rel_a;
        dur_attack[1]  = att_b;
        dur_release[1] = rel_b;
    endtask

    // ------------------------------------------------------------------
    // Tick sender: optional idle gap, then hold valid until accepted.
    // valid is only lowered when a gap follows, never toggled in one step.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic trig_a, input logic trig_b);
        int gap;
        gap = 0;
        while (gap < 40 && int'($urandom_range(99)) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.trigger_a <= trig_a;
        in_ch.trigger_b <= trig_b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_tick(trig_a, trig_b);
    endtask

    // Mostly sparse triggers so envelopes run their full course; one beat in
    // ten is noise with arbitrary trigger bits.
    task automatic send_random_tick(input int trig_pct);
        if ($urandom_range(9) == 0)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        else
            send_tick(int'($urandom_range(99)) < trig_pct,
                      int'($urandom_range(99)) < trig_pct);
    endtask

    // Stop offering ticks, wait for every level beat, then let the block settle.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (expected_levels_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [dare_pkg::CFG_W-1:0] random_duration();
        case ($urandom_range(9))
            0:       return dare_pkg::CFG_W'(1);
            1:       return dare_pkg::CFG_W'($urandom_range(100, 600));
            default: return dare_pkg::CFG_W'($urandom_range(2, 24));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset durations of 1000: slow ramps, both channels and a late retrigger.
    task automatic test_reset_durations();
        send_tick(1'b1, 1'b1);
        for (int i = 0; i < 19; i++)
            send_tick(1'b0, i == 9);
    endtask

    // Short durations walk every phase: idle, attack, exact equality with the
    // attack length, full scale on entering release, equality with the release
    // length, fall to zero, retrigger in attack and in release.
    task automatic test_directed_edges();
        quiesce();
        write_durations(24'd1, 24'd1, 24'd3, 24'd2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (6) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b0, 1'b0);
    endtask

    // Largest and smallest durations, then arbitrary full-width values.
    task automatic test_duration_extremes();
        quiesce();
        write_durations(TICK_MAX, TICK_MAX, 24'd1, 24'd1);
        send_tick(1'b1, 1'b1);
        for (int i = 0; i < 7; i++)
            send_tick(1'b0, i == 3);
        quiesce();
        write_durations(24'd1, TICK_MAX, TICK_MAX, 24'd1);
        send_tick(1'b1, 1'b1);
        repeat (5) send_tick(1'b0, 1'b0);
        quiesce();
        write_durations(dare_pkg::CFG_W'($urandom), dare_pkg::CFG_W'($urandom),
                        dare_pkg::CFG_W'($urandom), dare_pkg::CFG_W'($urandom));
        send_tick(1'b1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
    endtask

    // Random envelopes under each idling pattern, fresh durations per pattern.
    task automatic test_random_envelopes();
        int idle_pct [4];
        int stall_pct[4];
        idle_pct  = '{0, 75, 0, 21};
        stall_pct = '{0, 0, 75, 21};
        for (int p = 0; p < 4; p++)
        begin
            quiesce();
            write_durations(random_duration(), random_duration(),
                            random_duration(), random_duration());
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            repeat (90) send_random_tick(4);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // block backs up into its input; then the sender pauses until all drained.
    task automatic test_backpressure();
        quiesce();
        write_durations(24'd5, 24'd7, 24'd2, 24'd11);
        hold_req <= hold_req + 1;
        repeat (60) send_random_tick(10);
        in_ch.valid <= 1'b0;
        while (expected_levels_q.size() != 0)
            @(posedge clk);
        recv_stall_pct = 21;
        repeat (20) send_random_tick(10);
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = dare_pkg::REG_ATTACK_A;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.trigger_a = 1'b0;
        in_ch.trigger_b = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 0;
        mismatch_count  = 0;
        for (int c = 0; c < 2; c++)
        begin
            dur_attack[c]  = dare_pkg::DURATION_RESET;
            dur_release[c] = dare_pkg::DURATION_RESET;
            tick_count[c]  = '0;
            in_attack[c]   = 1'b0;
            level[c]       = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_durations();
        test_directed_edges();
        test_duration_extremes();
        test_random_envelopes();
        test_backpressure();

        quiesce();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold each time hold_req moves.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_seen;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= int'($urandom_range(99)) >= recv_stall_pct;
            end
        end
    end

    // ------------------------------------------------------------------
    // Level beat checker: every accepted beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_levels
        level_beat_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_levels_q.size() == 0)
            begin
                $error("level beat with no tick pending: level_a %0d level_b %0d",
                       out_ch.level_a, out_ch.level_b);
                mismatch_count++;
            end
            else
            begin
                want = expected_levels_q.pop_front();
                if (out_ch.level_a !== want.level_a)
                begin
                    $error("level_a expected %0d got %0d", want.level_a, out_ch.level_a);
                    mismatch_count++;
                end
                if (out_ch.level_b !== want.level_b)
                begin
                    $error("level_b expected %0d got %0d", want.level_b, out_ch.level_b);
                    mismatch_count++;
                end
                if (out_ch.attacking_a !== want.attacking_a)
                begin
                    $error("attacking_a expected %0b got %0b",
                           want.attacking_a, out_ch.attacking_a);
                    mismatch_count++;
                end
                if (out_ch.attacking_b !== want.attacking_b)
                begin
                    $error("attacking_b expected %0b got %0b",
                           want.attacking_b, out_ch.attacking_b);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat on either side means the block hung.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

`default_nettype wire
